>>> hdl/acb_pkg.sv
// Shared types, constants and helper functions for the arc to cubic Bezier core.
package acb_pkg;

	localparam int COORD_WIDTH     = 24;
	localparam int ANGLE_FRAC_BITS = 16;
	localparam int CORDIC_ITER_DEF = 18;

	localparam int ANGLE_WIDTH = ANGLE_FRAC_BITS + 4;
	localparam int PW          = COORD_WIDTH + 3;
	localparam int ZW          = 37;
	localparam int TW          = 32;
	localparam int ANG_SH      = 30 - ANGLE_FRAC_BITS;

	localparam longint PI_Q30      = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint TWO_PI_Q30  = 64'sd6746518852;
	localparam longint GAIN_Q30    = 64'sd652032874;

	localparam longint FULL_A    = (TWO_PI_Q30 + (64'sd1 <<< (ANG_SH - 1))) >>> ANG_SH;
	localparam longint QUARTER_A = (HALF_PI_Q30 + (64'sd1 <<< (ANG_SH - 1))) >>> ANG_SH;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] center_x;
		logic signed [COORD_WIDTH-1:0] center_y;
		logic [COORD_WIDTH-2:0]        radius;
		logic signed [ANGLE_WIDTH-1:0] start_angle;
		logic signed [ANGLE_WIDTH-1:0] end_angle;
		logic                          counter_clockwise;
	} arc_t;

	typedef struct packed {
		logic                          segment_kind;
		logic signed [COORD_WIDTH-1:0] ctrl1_x;
		logic signed [COORD_WIDTH-1:0] ctrl1_y;
		logic signed [COORD_WIDTH-1:0] ctrl2_x;
		logic signed [COORD_WIDTH-1:0] ctrl2_y;
		logic signed [COORD_WIDTH-1:0] end_x;
		logic signed [COORD_WIDTH-1:0] end_y;
		logic                          last;
	} seg_t;

	localparam logic KIND_MOVE  = 1'b0;
	localparam logic KIND_CUBIC = 1'b1;

	function automatic logic [TW-1:0] atan_q30(input logic [4:0] i);
		logic [TW-1:0] v;
		unique case (i)
			5'd0:  v = 32'd843314857;
			5'd1:  v = 32'd497837829;
			5'd2:  v = 32'd263043837;
			5'd3:  v = 32'd133525159;
			5'd4:  v = 32'd67021687;
			5'd5:  v = 32'd33543516;
			5'd6:  v = 32'd16775851;
			5'd7:  v = 32'd8388437;
			5'd8:  v = 32'd4194283;
			5'd9:  v = 32'd2097149;
			5'd10: v = 32'd1048576;
			5'd11: v = 32'd524288;
			5'd12: v = 32'd262144;
			5'd13: v = 32'd131072;
			5'd14: v = 32'd65536;
			5'd15: v = 32'd32768;
			5'd16: v = 32'd16384;
			5'd17: v = 32'd8192;
			5'd18: v = 32'd4096;
			5'd19: v = 32'd2048;
			5'd20: v = 32'd1024;
			5'd21: v = 32'd512;
			5'd22: v = 32'd256;
			5'd23: v = 32'd128;
			5'd24: v = 32'd64;
			5'd25: v = 32'd32;
			5'd26: v = 32'd16;
			5'd27: v = 32'd8;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [COORD_WIDTH-1:0] sat_coord(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] hi;
		logic signed [PW-1:0] lo;
		hi = PW'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
		lo = -hi - PW'(1);
		if (v > hi) return hi[COORD_WIDTH-1:0];
		else if (v < lo) return lo[COORD_WIDTH-1:0];
		else return v[COORD_WIDTH-1:0];
	endfunction

endpackage

>>> hdl/arc_to_cubic_bezier_core.sv
// Arc to cubic Bezier core: sequencer, CORDIC, divider and multiplier in one module.
//
//  channel | dir | payload        | handshake
//  --------+-----+----------------+----------------------------------------
//  arc     | in  | acb_pkg::arc_t | arc_valid / arc_stall, transfer when
//          |     |                | valid high and stall low
//  seg     | out | acb_pkg::seg_t | seg_valid / seg_stall, same rule
//
// One arc is taken at a time; arc_stall stays high until the last segment is
// loaded into the output register. Per arc: a serial restoring divide for the
// segment angle, one CORDIC for the quarter segment angle and another divide for
// alpha, then per point (start plus N ends) an angle reduction, a CORDIC of
// CORDIC_ITERATIONS iterations and the multiplies for the point and its offsets.
// A sweep under two angle units is dropped. Reset clears the sequencer and the
// output valid; seg_stall only holds the sequencer before each output write.
module arc_to_cubic_bezier_core #(
	parameter int CORDIC_ITERATIONS = acb_pkg::CORDIC_ITER_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           arc_valid,
	output logic           arc_stall,
	input  acb_pkg::arc_t  arc,
	output logic           seg_valid,
	input  logic           seg_stall,
	output acb_pkg::seg_t  seg
);
	import acb_pkg::*;

	localparam int CW    = COORD_WIDTH;
	localparam int SWW   = ANGLE_WIDTH + 2;
	localparam int SGW   = ANGLE_FRAC_BITS + 5;
	localparam int ANGW  = ANGLE_FRAC_BITS + 6;
	localparam int AW    = 33;
	localparam int MW    = 34;
	localparam int PRW   = 2 * MW;
	localparam int NUMW  = 64;
	localparam int DENW  = 34;
	localparam logic [4:0] ILAST = 5'(CORDIC_ITERATIONS - 1);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_PREP  = 4'd1;
	localparam logic [3:0] ST_DIV   = 4'd2;
	localparam logic [3:0] ST_CRED  = 4'd3;
	localparam logic [3:0] ST_CFOLD = 4'd4;
	localparam logic [3:0] ST_CITER = 4'd5;
	localparam logic [3:0] ST_MUL   = 4'd6;
	localparam logic [3:0] ST_EMIT  = 4'd7;

	localparam logic [1:0] PH_SEG   = 2'd0;
	localparam logic [1:0] PH_ALPHA = 2'd1;
	localparam logic [1:0] PH_START = 2'd2;
	localparam logic [1:0] PH_POINT = 2'd3;

	localparam logic signed [ZW-1:0] Z_PI   = ZW'(PI_Q30);
	localparam logic signed [ZW-1:0] Z_HPI  = ZW'(HALF_PI_Q30);
	localparam logic signed [ZW-1:0] Z_2PI  = ZW'(TWO_PI_Q30);
	localparam logic signed [TW-1:0] T_GAIN = TW'(GAIN_Q30);
	localparam logic signed [SWW-1:0] S_FULL = SWW'(FULL_A);
	localparam logic [SWW-1:0] MAG_MAX = SWW'(8 * QUARTER_A - 1);

	localparam logic signed [PRW-1:0] H30 = PRW'(1) <<< 29;
	localparam logic signed [PRW-1:0] HRS = PRW'(1) <<< (CW - 3);
	localparam logic signed [PRW-1:0] HOF = PRW'(1) <<< (61 - CW);

	logic [3:0] st_q;
	logic [1:0] ph_q;
	logic       out_valid_q;
	seg_t       out_q;
	arc_t       in_q;

	// sweep bookkeeping
	logic              neg_q;
	logic [3:0]        n_q;
	logic [2:0]        k_q;
	logic signed [SGW-1:0]  seg_ang_q;
	logic signed [ANGW-1:0] ang_q;
	logic signed [AW-1:0]   alpha_q;
	logic              qneg_q;

	// divider
	logic [NUMW-1:0] num_q;
	logic [DENW-1:0] rem_q;
	logic [DENW-1:0] den_q;
	logic [5:0]      dcnt_q;

	// CORDIC
	logic signed [ZW-1:0] z_q;
	logic signed [TW-1:0] x_q, y_q;
	logic signed [TW-1:0] c_q, s_q;
	logic                 fold_q;
	logic [4:0]           i_q;

	// multiplier and point registers
	logic signed [MW-1:0]  ma_q, mb_q;
	logic signed [PRW-1:0] prod_q;
	logic [3:0]            mstep_q;
	logic signed [PW-1:0]  px_q, py_q, os_q, oc_q;
	logic signed [PW-1:0]  ppx_q, ppy_q, pos_q, poc_q;

	// sweep setup
	logic signed [SWW-1:0] sweep0, sweep1;
	logic [SWW-1:0]        mag, magc;
	logic [3:0]            n_c;

	always_comb begin
		sweep0 = SWW'(in_q.end_angle) - SWW'(in_q.start_angle);
		sweep1 = sweep0;
		if (in_q.counter_clockwise) begin
			if (sweep0 > 0) sweep1 = sweep0 - S_FULL;
		end else begin
			if (sweep0 < 0) sweep1 = sweep0 + S_FULL;
		end
		mag  = sweep1[SWW-1] ? SWW'(-sweep1) : SWW'(sweep1);
		magc = (mag > MAG_MAX) ? MAG_MAX : mag;
		n_c  = 4'd1;
		for (int k = 1; k < 8; k++) begin
			if (magc >= SWW'(k * QUARTER_A)) n_c = n_c + 4'd1;
		end
	end

	// divider step: shift one numerator bit into the remainder
	logic [DENW:0]   trial;
	logic            qbit;
	logic [DENW-1:0] rem_n;
	logic [NUMW-1:0] num_n;

	always_comb begin
		trial = {rem_q, num_q[NUMW-1]};
		qbit  = (trial >= {1'b0, den_q});
		rem_n = qbit ? DENW'(trial - {1'b0, den_q}) : trial[DENW-1:0];
		num_n = {num_q[NUMW-2:0], qbit};
	end

	// CORDIC step and result
	logic signed [TW-1:0] dx, dy, x_n, y_n, cos_v, sin_v;
	logic signed [ZW-1:0] at, z_n;

	always_comb begin
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
		at = ZW'(atan_q30(i_q));
		if (z_q >= 0) begin
			x_n = x_q - dx;
			y_n = y_q + dy;
			z_n = z_q - at;
		end else begin
			x_n = x_q + dx;
			y_n = y_q - dy;
			z_n = z_q + at;
		end
		cos_v = fold_q ? -x_n : x_n;
		sin_v = fold_q ? -y_n : y_n;
	end

	// rounded views of the product
	logic signed [PRW-1:0] r30, rrs, rof;
	assign r30 = (prod_q + H30) >>> 30;
	assign rrs = (prod_q + HRS) >>> (CW - 2);
	assign rof = (prod_q + HOF) >>> (62 - CW);

	logic signed [ANGW-1:0] ang_next;
	logic signed [SGW-1:0]  seg_v;
	logic signed [AW-1:0]   alpha_v;
	logic                   out_free;
	logic                   emit_go;
	logic                   is_last;

	assign ang_next = ang_q + ANGW'(seg_ang_q);
	assign seg_v    = neg_q ? -$signed(num_n[SGW-1:0]) : $signed(num_n[SGW-1:0]);
	assign alpha_v  = qneg_q ? -$signed(num_n[AW-1:0]) : $signed(num_n[AW-1:0]);
	assign out_free = !out_valid_q || !seg_stall;
	assign emit_go  = (st_q == ST_EMIT) && out_free;
	assign is_last  = (k_q == 3'(n_q - 4'd1));

	always_ff @(posedge clk) begin
		prod_q <= ma_q * mb_q;
	end

	// raise the output on a write, drop it once it transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (!seg_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			ph_q        <= PH_SEG;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (arc_valid) begin
						in_q <= arc;
						st_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					ang_q <= ANGW'(in_q.start_angle);
					neg_q <= sweep1[SWW-1];
					n_q   <= n_c;
					if (mag < SWW'(2)) begin
						st_q <= ST_IDLE;
					end else begin
						num_q  <= NUMW'(magc);
						den_q  <= DENW'(n_c);
						rem_q  <= '0;
						dcnt_q <= '0;
						ph_q   <= PH_SEG;
						st_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					num_q  <= num_n;
					rem_q  <= rem_n;
					dcnt_q <= dcnt_q + 6'd1;
					if (dcnt_q == 6'd63) begin
						st_q <= ST_CRED;
						if (ph_q == PH_SEG) begin
							seg_ang_q <= seg_v;
							z_q <= ZW'(seg_v) <<< (ANG_SH - 2);
						end else begin
							alpha_q <= alpha_v;
							z_q  <= ZW'(in_q.start_angle) <<< ANG_SH;
							ph_q <= PH_START;
						end
					end
				end
				ST_CRED: begin
					// bring the angle into [-pi, pi)
					if (z_q >= Z_PI) z_q <= z_q - Z_2PI;
					else if (z_q < -Z_PI) z_q <= z_q + Z_2PI;
					else st_q <= ST_CFOLD;
				end
				ST_CFOLD: begin
					fold_q <= (z_q > Z_HPI) || (z_q < -Z_HPI);
					if (z_q > Z_HPI) begin
						z_q    <= z_q - Z_PI;
					end else if (z_q < -Z_HPI) begin
						z_q    <= z_q + Z_PI;
					end
					x_q  <= T_GAIN;
					y_q  <= '0;
					i_q  <= '0;
					st_q <= ST_CITER;
				end
				ST_CITER: begin
					x_q <= x_n;
					y_q <= y_n;
					z_q <= z_n;
					i_q <= i_q + 5'd1;
					if (i_q == ILAST) begin
						c_q <= cos_v;
						s_q <= sin_v;
						if (ph_q == PH_SEG) begin
							if (cos_v > 0) begin
								num_q  <= {(sin_v[TW-1] ? TW'(-sin_v) : TW'(sin_v)), 32'b0};
								den_q  <= DENW'(cos_v) + (DENW'(cos_v) << 1);
								rem_q  <= '0;
								dcnt_q <= '0;
								qneg_q <= sin_v[TW-1];
								ph_q   <= PH_ALPHA;
								st_q   <= ST_DIV;
							end else begin
								alpha_q <= '0;
								z_q  <= ZW'(in_q.start_angle) <<< ANG_SH;
								ph_q <= PH_START;
								st_q <= ST_CRED;
							end
						end else begin
							mstep_q <= '0;
							st_q    <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					mstep_q <= mstep_q + 4'd1;
					unique case (mstep_q)
						4'd0: begin
							ma_q <= MW'(in_q.radius);
							mb_q <= MW'(c_q);
						end
						4'd2: begin
							px_q <= PW'(in_q.center_x) + r30[PW-1:0];
							ma_q <= MW'(alpha_q);
							mb_q <= rrs[MW-1:0];
						end
						4'd4: begin
							oc_q <= rof[PW-1:0];
							ma_q <= MW'(in_q.radius);
							mb_q <= MW'(s_q);
						end
						4'd6: begin
							py_q <= PW'(in_q.center_y) + r30[PW-1:0];
							ma_q <= MW'(alpha_q);
							mb_q <= rrs[MW-1:0];
						end
						4'd8: begin
							os_q <= rof[PW-1:0];
							st_q <= ST_EMIT;
						end
						default: begin
						end
					endcase
				end
				ST_EMIT: begin
					if (out_free) begin
						ppx_q <= px_q;
						ppy_q <= py_q;
						pos_q <= os_q;
						poc_q <= oc_q;
						out_q.end_x <= sat_coord(px_q);
						out_q.end_y <= sat_coord(py_q);
						if (ph_q == PH_START) begin
							out_q.segment_kind <= KIND_MOVE;
							out_q.ctrl1_x <= '0;
							out_q.ctrl1_y <= '0;
							out_q.ctrl2_x <= '0;
							out_q.ctrl2_y <= '0;
							out_q.last    <= 1'b0;
							ph_q  <= PH_POINT;
							k_q   <= '0;
							ang_q <= ang_next;
							z_q   <= ZW'(ang_next) <<< ANG_SH;
							st_q  <= ST_CRED;
						end else begin
							out_q.segment_kind <= KIND_CUBIC;
							out_q.ctrl1_x <= sat_coord(ppx_q - pos_q);
							out_q.ctrl1_y <= sat_coord(ppy_q + poc_q);
							out_q.ctrl2_x <= sat_coord(px_q + os_q);
							out_q.ctrl2_y <= sat_coord(py_q - oc_q);
							out_q.last    <= is_last;
							if (is_last) begin
								st_q <= ST_IDLE;
							end else begin
								k_q   <= k_q + 3'd1;
								ang_q <= ang_next;
								z_q   <= ZW'(ang_next) <<< ANG_SH;
								st_q  <= ST_CRED;
							end
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign arc_stall = (st_q != ST_IDLE);
	assign seg_valid = out_valid_q;
	assign seg       = out_q;

endmodule

>>> tb/tb_arc_to_cubic_bezier_core.sv
// Regression bench for the arc to cubic Bezier core: random and directed arcs against a predictor.
`timescale 1ns / 100ps

module tb_arc_to_cubic_bezier_core;
	import acb_pkg::*;

	localparam int CORDIC_ITERATIONS = CORDIC_ITER_DEF;
	localparam int IDLE_LIMIT        = 20000;
	localparam longint MAX_SWEEP     = 8 * QUARTER_A - 1;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  arc_valid = 1'b0;
	logic  arc_stall;
	arc_t  arc = '0;
	logic  seg_valid;
	logic  seg_stall = 1'b0;
	seg_t  seg;

	seg_t  segs_due[$];
	int    mismatches = 0;
	int    arcs_sent = 0;
	int    segs_seen = 0;
	int    idle_cycles = 0;
	bit    sender_idles = 1'b1;
	bit    receiver_idles = 1'b1;
	bit    hold_receiver = 1'b0;

	arc_to_cubic_bezier_core #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) dut (
		.clk(clk), .arst_n(arst_n),
		.arc_valid(arc_valid), .arc_stall(arc_stall), .arc(arc),
		.seg_valid(seg_valid), .seg_stall(seg_stall), .seg(seg)
	);

	always #1 clk = ~clk;

	// Round to nearest with ties up.
	function automatic longint round_shift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic logic [COORD_WIDTH-1:0] clamp_coord(longint v);
		longint hi;
		longint lo;
		hi = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) v = hi;
		if (v < lo) v = lo;
		return v[COORD_WIDTH-1:0];
	endfunction

	// Rotation-mode CORDIC on a Q.30 angle; cosine and sine come back in Q.30.
	task automatic rotate_unit(input longint ang, output longint cs, output longint sn);
		longint x;
		longint y;
		longint t;
		longint dx;
		longint dy;
		longint step;
		bit     flip;
		x = GAIN_Q30;
		y = 0;
		flip = 1'b0;
		t = (ang + PI_Q30) % TWO_PI_Q30;
		if (t < 0) t += TWO_PI_Q30;
		ang = t - PI_Q30;
		if (ang > HALF_PI_Q30) begin
			ang -= PI_Q30;
			flip = 1'b1;
		end else if (ang < -HALF_PI_Q30) begin
			ang += PI_Q30;
			flip = 1'b1;
		end
		for (int i = 0; i < CORDIC_ITERATIONS && i < 28; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			step = longint'(atan_q30(5'(i)));
			if (ang >= 0) begin
				x -= dx; y += dy; ang -= step;
			end else begin
				x += dx; y -= dy; ang += step;
			end
		end
		cs = flip ? -x : x;
		sn = flip ? -y : y;
	endtask

	function automatic longint ctrl_offset(longint alpha, longint r, longint trig);
		longint rs;
		rs = round_shift(r * trig, COORD_WIDTH - 2);
		return round_shift(alpha * rs, 62 - COORD_WIDTH);
	endfunction

	// Work out the move and cubic segments for one arc and queue them.
	task automatic predict_segments(input arc_t a);
		longint cx, cy, r, sa, sweep, mag, seg_ang, nxt, cur;
		longint qc, qs, alpha, c1, s1, c2, s2, x1, y1, x2, y2;
		int     n;
		seg_t   s;
		cx = longint'(a.center_x);
		cy = longint'(a.center_y);
		r = longint'({1'b0, a.radius});
		sa = longint'(a.start_angle);
		sweep = longint'(a.end_angle) - sa;
		if (a.counter_clockwise) begin
			if (sweep > 0) sweep -= FULL_A;
		end else begin
			if (sweep < 0) sweep += FULL_A;
		end
		mag = sweep < 0 ? -sweep : sweep;
		if (mag < 2) return;
		if (mag > MAX_SWEEP) begin
			mag = MAX_SWEEP;
			sweep = sweep < 0 ? -mag : mag;
		end
		n = int'(mag / QUARTER_A) + 1;
		seg_ang = sweep / n;
		rotate_unit((seg_ang <<< ANG_SH) / 4, qc, qs);
		alpha = qc > 0 ? (qs * (64'sd1 <<< 32)) / (3 * qc) : 0;
		rotate_unit(sa <<< ANG_SH, c1, s1);
		x1 = cx + round_shift(r * c1, 30);
		y1 = cy + round_shift(r * s1, 30);
		s = '0;
		s.segment_kind = KIND_MOVE;
		s.end_x = clamp_coord(x1);
		s.end_y = clamp_coord(y1);
		segs_due = {segs_due, s};
		cur = sa;
		for (int k = 0; k < n; k++) begin
			nxt = cur + seg_ang;
			rotate_unit(nxt <<< ANG_SH, c2, s2);
			x2 = cx + round_shift(r * c2, 30);
			y2 = cy + round_shift(r * s2, 30);
			s.segment_kind = KIND_CUBIC;
			s.ctrl1_x = clamp_coord(x1 - ctrl_offset(alpha, r, s1));
			s.ctrl1_y = clamp_coord(y1 + ctrl_offset(alpha, r, c1));
			s.ctrl2_x = clamp_coord(x2 + ctrl_offset(alpha, r, s2));
			s.ctrl2_y = clamp_coord(y2 - ctrl_offset(alpha, r, c2));
			s.end_x = clamp_coord(x2);
			s.end_y = clamp_coord(y2);
			s.last = (k == n - 1);
			segs_due = {segs_due, s};
			x1 = x2; y1 = y2; c1 = c2; s1 = s2; cur = nxt;
		end
	endtask

	// Offer one arc, hold it until transfer, predict it at the transfer edge.
	// Valid stays up into the next call, which replaces or drops it.
	task automatic send_arc(input arc_t a);
		if (sender_idles && $urandom_range(0, 3) == 0) begin
			arc_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		arc <= a;
		arc_valid <= 1'b1;
		do @(posedge clk); while (arc_stall);
		predict_segments(a);
		arcs_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		arc_valid <= 1'b0;
		while (segs_due.size() != 0) @(negedge clk);
		// a dropped tiny sweep may still be in flight
		repeat (10) @(negedge clk);
	endtask

	function automatic arc_t make_arc(longint cx, longint cy, longint r, longint sa,
			longint ea, bit ccw);
		arc_t a;
		a.center_x = cx[COORD_WIDTH-1:0];
		a.center_y = cy[COORD_WIDTH-1:0];
		a.radius = r[COORD_WIDTH-2:0];
		a.start_angle = sa[ANGLE_WIDTH-1:0];
		a.end_angle = ea[ANGLE_WIDTH-1:0];
		a.counter_clockwise = ccw;
		return a;
	endfunction

	function automatic longint rand_angle();
		return longint'($urandom_range(0, 823550)) - 411775;
	endfunction

	function automatic arc_t random_arc();
		arc_t         a;
		longint       sa;
		logic [127:0] bits;
		bits = {$urandom, $urandom, $urandom, $urandom};
		a = bits[$bits(arc_t)-1:0];
		sa = rand_angle();
		a.start_angle = sa[ANGLE_WIDTH-1:0];
		case ($urandom_range(0, 9))
			0: a.end_angle = ANGLE_WIDTH'(sa + $urandom_range(0, 4) - 2);
			1: a.end_angle = a.end_angle;
			default: a.end_angle = ANGLE_WIDTH'(rand_angle());
		endcase
		// mostly moderate geometry so the curves stay in range; some full-scale
		if ($urandom_range(0, 3) != 0) begin
			a.center_x = COORD_WIDTH'($signed($urandom_range(0, 2000000)) - 1000000);
			a.center_y = COORD_WIDTH'($signed($urandom_range(0, 2000000)) - 1000000);
			a.radius = (COORD_WIDTH-1)'($urandom_range(0, 1500000));
		end
		return a;
	endfunction

	task automatic test_extremes();
		longint m;
		m = (64'sd1 <<< (COORD_WIDTH - 1));
		send_arc(make_arc(0, 0, 256, 0, 102944, 1'b0));
		send_arc(make_arc(m - 1, m - 1, m - 1, 0, 205887, 1'b0));
		send_arc(make_arc(-m, -m, m - 1, -411775, 411775, 1'b1));
		send_arc(make_arc(-m, m - 1, 0, 411775, -411775, 1'b0));
		send_arc(make_arc(1000, -1000, 5000, 524287, -524288, 1'b1));
		send_arc(make_arc(0, 0, 4096, -524288, 524287, 1'b0));
		wait_drained();
	endtask

	task automatic test_sweep_cases();
		// tiny sweeps, both directions, then exact quarter boundaries
		send_arc(make_arc(100, 100, 1000, 5000, 5000, 1'b0));
		send_arc(make_arc(100, 100, 1000, 5000, 5001, 1'b0));
		send_arc(make_arc(100, 100, 1000, 5000, 4999, 1'b1));
		send_arc(make_arc(100, 100, 1000, 5000, 5002, 1'b0));
		send_arc(make_arc(100, 100, 1000, 5000, 4998, 1'b1));
		send_arc(make_arc(0, 0, 20000, 0, QUARTER_A, 1'b0));
		send_arc(make_arc(0, 0, 20000, 0, QUARTER_A - 1, 1'b0));
		send_arc(make_arc(0, 0, 20000, 0, -QUARTER_A, 1'b1));
		// wrapped sweeps: the wrong sign survives one turn in the first two
		send_arc(make_arc(0, 0, 20000, -411775, 411775, 1'b1));
		send_arc(make_arc(0, 0, 20000, 411775, -411775, 1'b0));
		send_arc(make_arc(0, 0, 20000, 300000, 100, 1'b0));
		send_arc(make_arc(0, 0, 20000, 100, 300000, 1'b1));
		wait_drained();
	endtask

	task automatic test_random(input int count);
		repeat (count) send_arc(random_arc());
	endtask

	task automatic test_backpressure();
		// hold the output off while the sender keeps offering arcs
		hold_receiver = 1'b1;
		repeat (4) send_arc(make_arc(0, 0, 30000, 0, MAX_SWEEP, 1'b0));
		wait_drained();
		// pause the sender until everything is out, then one more burst
		repeat (5) send_arc(random_arc());
		wait_drained();
	endtask

	task automatic test_no_idle(input int count);
		sender_idles = 1'b0;
		receiver_idles = 1'b0;
		repeat (count) send_arc(random_arc());
	endtask

	// Receiver: random stall bursts, plus a long hold-off when asked.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_receiver) begin
				seg_stall <= 1'b1;
				repeat (3000) @(negedge clk);
				hold_receiver = 1'b0;
				seg_stall <= 1'b0;
			end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
				seg_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(negedge clk);
				seg_stall <= 1'b0;
			end
		end
	end

	// Compare each transferred segment with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && seg_valid && !seg_stall) begin
			segs_seen++;
			if (segs_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected segment %h", $time, seg);
			end else begin
				seg_t want;
				want = segs_due.pop_front();
				if (seg.segment_kind !== want.segment_kind) begin
					mismatches++;
					$display("%0t: segment_kind exp %0d got %0d", $time,
						want.segment_kind, seg.segment_kind);
				end
				if (seg.ctrl1_x !== want.ctrl1_x) begin
					mismatches++;
					$display("%0t: ctrl1_x exp %0d got %0d", $time, want.ctrl1_x, seg.ctrl1_x);
				end
				if (seg.ctrl1_y !== want.ctrl1_y) begin
					mismatches++;
					$display("%0t: ctrl1_y exp %0d got %0d", $time, want.ctrl1_y, seg.ctrl1_y);
				end
				if (seg.ctrl2_x !== want.ctrl2_x) begin
					mismatches++;
					$display("%0t: ctrl2_x exp %0d got %0d", $time, want.ctrl2_x, seg.ctrl2_x);
				end
				if (seg.ctrl2_y !== want.ctrl2_y) begin
					mismatches++;
					$display("%0t: ctrl2_y exp %0d got %0d", $time, want.ctrl2_y, seg.ctrl2_y);
				end
				if (seg.end_x !== want.end_x) begin
					mismatches++;
					$display("%0t: end_x exp %0d got %0d", $time, want.end_x, seg.end_x);
				end
				if (seg.end_y !== want.end_y) begin
					mismatches++;
					$display("%0t: end_y exp %0d got %0d", $time, want.end_y, seg.end_y);
				end
				if (seg.last !== want.last) begin
					mismatches++;
					$display("%0t: last exp %0d got %0d", $time, want.last, seg.last);
				end
			end
		end
	end

	// Watchdog: count cycles with no transfer on either channel.
	always @(posedge clk) begin
		if ((arc_valid && !arc_stall) || (seg_valid && !seg_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("arc_to_cubic_bezier_core regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_extremes();
		test_sweep_cases();
		test_random(300);
		test_backpressure();
		test_no_idle(130);
		wait_drained();
		repeat (500) @(negedge clk);
		$display("covered %0d arcs and %0d segments: extremes, tiny and wrapped sweeps,",
			arcs_sent, segs_seen);
		$display("random geometry, long output hold-off and drained pauses");
		if (mismatches == 0 && segs_due.size() == 0)
			$display("arc_to_cubic_bezier_core regression: pass");
		else
			$display("arc_to_cubic_bezier_core regression: fail");
		$finish;
	end

endmodule

>>> filelist.f
hdl/acb_pkg.sv
hdl/arc_to_cubic_bezier_core.sv
tb/tb_arc_to_cubic_bezier_core.sv
